// ===== src/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// Used by bpa_bitmap_ram and bitmap_page_allocator_unit; no dependencies.
package bpa_pkg;

  localparam int CNT_W = 13;
  localparam int STATUS_W = 3;
  localparam int OP_W = 2;
  localparam int IDX_W = 1;
  localparam int DEF_MAX_PAGE_COUNT = 4096;
  localparam int DEF_PAGE_BITS = 12;
  localparam int DEF_ADDR_WIDTH = 32;
  localparam int WORD_BITS = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_ZERO      = 3'd2,
    ST_NO_RUN    = 3'd3,
    ST_RANGE     = 3'd4,
    ST_UNALIGNED = 3'd5,
    ST_DOUBLE    = 3'd6
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_HEAP_BASE  = 1'd0,
    REG_PAGE_COUNT = 1'd1
  } reg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_A_RD  = 7'b0000010,
    S_A_BIT = 7'b0000100,
    S_M_RD  = 7'b0001000,
    S_M_WR  = 7'b0010000,
    S_F_RD  = 7'b0100000,
    S_F_WR  = 7'b1000000
  } state_t;

endpackage

// ===== src/bpa_bitmap_ram.sv =====
// Used-bit memory: 32-bit words, one read and one write port, registered read.
// Per-word valid bits give an all-free map after reset or clear. Uses bpa_pkg.
module bpa_bitmap_ram import bpa_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid;

  // write the word array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // track which words hold written data
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // read; an unwritten word reads as all free
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ===== src/bitmap_page_allocator_unit.sv =====
// Bitmap first-fit page allocator. Init: result in the next cycle, busy stays low.
// Alloc: scans the pages one by one, reading each 32-page word before its pages, then
// marks the run with a read and a write-back per marked word. Free: walks the pages one
// by one; a page in range and aligned has its word read and written back. done strobes the
// result in the cycle after the last step; the next request is accepted in that cycle.
// Synchronous reset clears state, config, ready, free count, used bits at once; no stall.
module bitmap_page_allocator_unit import bpa_pkg::*; #(
  parameter int MAX_PAGE_COUNT = DEF_MAX_PAGE_COUNT,
  parameter int PAGE_BITS = DEF_PAGE_BITS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [(ADDR_WIDTH > CNT_W ? ADDR_WIDTH : CNT_W)-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op,
  input  logic [CNT_W-1:0]      count,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  done,
  output logic [ADDR_WIDTH-1:0] alloc_address,
  output logic [STATUS_W-1:0]   status,
  output logic [CNT_W-1:0]      pages_freed,
  output logic [CNT_W-1:0]      free_count
);

  localparam int AW = ADDR_WIDTH;
  localparam int TW = $clog2(MAX_PAGE_COUNT + 1);
  localparam int DEPTH = (MAX_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int PIW = WAW + 5;
  localparam int CMPW = AW + TW;

  logic [AW-1:0]    heap_base;
  logic [CNT_W-1:0] page_count;
  logic [TW-1:0]    total;
  logic [TW-1:0]    free_total;
  logic             ready;
  state_t           state;

  logic [CNT_W-1:0] cnt;
  logic [TW-1:0]    ai;
  logic [CNT_W-1:0] run;
  logic [PIW-1:0]   ms;
  logic [PIW-1:0]   mend;
  logic [WAW-1:0]   mw;
  logic [CNT_W-1:0] fi;
  logic [AW-1:0]    fpa;
  logic [PIW-1:0]   fidx_q;
  logic [CNT_W-1:0] freed;
  status_t          ferr;

  logic                 rd_en, wr_en, mclr;
  logic [WAW-1:0]       rd_addr, wr_addr;
  logic [WORD_BITS-1:0] rd_data, wr_data, mark_mask;
  logic [PIW-1:0]       ai_p, found_start;
  logic [AW-1:0]        foff, fpg;
  logic [PIW-1:0]       fidx;
  logic                 frange, funal, abit_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      page_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_HEAP_BASE) begin
        heap_base <= cfg_data[AW-1:0];
      end else if (cfg_index == REG_PAGE_COUNT) begin
        page_count <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // clamp the page count to the map size
  always_comb begin
    if (32'(page_count) > 32'(MAX_PAGE_COUNT)) begin
      total = TW'(MAX_PAGE_COUNT);
    end else begin
      total = TW'(page_count);
    end
  end

  // free-walk page checks
  assign foff   = fpa - heap_base;
  assign fpg    = foff >> PAGE_BITS;
  assign frange = CMPW'(fpg) >= CMPW'(total);
  assign funal  = fpa[PAGE_BITS-1:0] != '0;
  assign fidx   = PIW'(fpg);

  assign ai_p        = PIW'(ai);
  assign abit_free   = !rd_data[ai_p[4:0]];
  assign found_start = (run == '0) ? ai_p : ms;

  // mask of pages in the run that fall into word mw
  always_comb begin
    logic [PIW-1:0] p;
    for (int b = 0; b < WORD_BITS; b++) begin
      p = {mw, 5'(b)};
      mark_mask[b] = (p >= ms) && (p <= mend);
    end
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    mclr    = 1'b0;
    case (state)
      S_IDLE: mclr = start && (op == OP_INIT);
      S_A_RD: begin
        rd_en   = 1'b1;
        rd_addr = ai_p[PIW-1:5];
      end
      S_M_RD: begin
        rd_en   = 1'b1;
        rd_addr = mw;
      end
      S_M_WR: begin
        wr_en   = 1'b1;
        wr_addr = mw;
        wr_data = rd_data | mark_mask;
      end
      S_F_RD: begin
        rd_en   = !frange && !funal;
        rd_addr = fidx[PIW-1:5];
      end
      S_F_WR: begin
        wr_en   = rd_data[fidx_q[4:0]];
        wr_addr = fidx_q[PIW-1:5];
        wr_data = rd_data & ~(WORD_BITS'(1) << fidx_q[4:0]);
      end
      default: ;
    endcase
  end

  bpa_bitmap_ram #(
    .DEPTH(DEPTH),
    .AW(WAW)
  ) u_ram (
    .clk(clk),
    .rst(rst),
    .clear(mclr),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    logic             last;
    logic             derr;
    logic             done_n;
    status_t          st_n;
    status_t          ferr_n;
    logic [CNT_W-1:0] freed_n;
    if (rst) begin
      state      <= S_IDLE;
      ready      <= 1'b0;
      free_total <= '0;
      done       <= 1'b0;
    end else begin
      done_n = 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            st_n = ST_OK;
            cnt           <= count;
            alloc_address <= '0;
            pages_freed   <= '0;
            case (op)
              OP_INIT: begin
                free_total <= total;
                ready      <= 1'b1;
                done_n     = 1'b1;
              end
              OP_ALLOC: begin
                if (!ready) begin
                  st_n   = ST_NOT_READY;
                  done_n = 1'b1;
                end else if (count == '0) begin
                  st_n   = ST_ZERO;
                  done_n = 1'b1;
                end else if (32'(count) > 32'(total)) begin
                  st_n   = ST_NO_RUN;
                  done_n = 1'b1;
                end else begin
                  ai    <= '0;
                  run   <= '0;
                  state <= S_A_RD;
                end
              end
              OP_FREE: begin
                if (!ready) begin
                  st_n   = ST_NOT_READY;
                  done_n = 1'b1;
                end else if (count == '0) begin
                  done_n = 1'b1;
                end else begin
                  fi    <= '0;
                  fpa   <= address;
                  freed <= '0;
                  ferr  <= ST_OK;
                  state <= S_F_RD;
                end
              end
              default: done_n = 1'b1;
            endcase
            status <= st_n;
          end
        end
        S_A_RD: state <= S_A_BIT;
        S_A_BIT: begin
          if (abit_free && (run + 1'b1 == cnt)) begin
            ms    <= found_start;
            mend  <= found_start + PIW'(cnt) - 1'b1;
            mw    <= found_start[PIW-1:5];
            state <= S_M_RD;
          end else if (ai + 1'b1 == total) begin
            status <= ST_NO_RUN;
            done_n = 1'b1;
            state  <= S_IDLE;
          end else begin
            if (abit_free) begin
              if (run == '0) begin
                ms <= ai_p;
              end
              run <= run + 1'b1;
            end else begin
              run <= '0;
            end
            ai <= ai + 1'b1;
            if (ai_p[4:0] == 5'd31) begin
              state <= S_A_RD;
            end
          end
        end
        S_M_RD: state <= S_M_WR;
        S_M_WR: begin
          if (mw == mend[PIW-1:5]) begin
            if (CMPW'(free_total) > CMPW'(cnt)) begin
              free_total <= free_total - TW'(cnt);
            end else begin
              free_total <= '0;
            end
            alloc_address <= heap_base + (AW'(ms) << PAGE_BITS);
            done_n = 1'b1;
            state         <= S_IDLE;
          end else begin
            mw    <= mw + 1'b1;
            state <= S_M_RD;
          end
        end
        S_F_RD, S_F_WR: begin
          last    = 1'b0;
          derr    = 1'b0;
          ferr_n  = ferr;
          freed_n = freed;
          if (state == S_F_RD && (frange || funal)) begin
            if (ferr == ST_OK) begin
              ferr_n = frange ? ST_RANGE : ST_UNALIGNED;
            end
            last = 1'b1;
          end else if (state == S_F_RD) begin
            fidx_q <= fidx;
            state  <= S_F_WR;
          end else begin
            derr = !rd_data[fidx_q[4:0]];
            if (derr) begin
              if (ferr == ST_OK) begin
                ferr_n = ST_DOUBLE;
              end
            end else begin
              freed_n = freed + 1'b1;
              if (32'(free_total) < 32'(MAX_PAGE_COUNT)) begin
                free_total <= free_total + 1'b1;
              end
            end
            last = 1'b1;
          end
          ferr  <= ferr_n;
          freed <= freed_n;
          // advance the walk by one page, or finish it after the last page
          if (last) begin
            if (fi + 1'b1 == cnt) begin
              done_n = 1'b1;
              state       <= S_IDLE;
              status      <= ferr_n;
              pages_freed <= freed_n;
            end else begin
              fi    <= fi + 1'b1;
              fpa   <= fpa + (AW'(1) << PAGE_BITS);
              state <= S_F_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      done <= done_n;
    end
  end

  assign busy       = state != S_IDLE;
  assign free_count = CNT_W'(free_total);

`ifndef NO_ASSERTIONS
  a_init_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_INIT) |=> (done && status == ST_OK && !busy))
    else $error("init request did not complete in one cycle");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (alloc_address == '0))
    else $error("failed request returned an address");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("bitmap read and write in the same cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while sequencer busy");
`endif

endmodule
